// ===== hdl/tmhq_pkg.sv =====
// Package with sizes, codes and the heap entry type of the timer heap queue.
package tmhq_pkg;
    localparam int HEAP_DEPTH   = 32;
    localparam int HANDLE_COUNT = 64;
    localparam int TIME_BITS    = 48;
    localparam int SLOT_W       = $clog2(HEAP_DEPTH);
    localparam int CNT_W        = $clog2(HEAP_DEPTH + 1);
    localparam int HANDLE_W     = 6;
    localparam int DELAY_W      = 32;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_DEL = 2'd1;
    localparam logic [1:0] MODE_POP = 2'd2;
    localparam logic [1:0] MODE_TOP = 2'd3;

    localparam logic [2:0] ST_FIRED   = 3'd0;
    localparam logic [2:0] ST_TOP     = 3'd1;
    localparam logic [2:0] ST_POPPED  = 3'd2;
    localparam logic [2:0] ST_DELETED = 3'd3;
    localparam logic [2:0] ST_ADDED   = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;
    localparam logic [2:0] ST_FULL    = 3'd6;
    localparam logic [2:0] ST_BAD     = 3'd7;

    typedef struct packed {
        logic [HANDLE_W-1:0]  handle;
        logic [TIME_BITS-1:0] expiry;
    } entry_t;

    typedef struct packed {
        logic [1:0]           mode;
        logic [HANDLE_W-1:0]  handle;
        logic [DELAY_W-1:0]   delay;
        logic [TIME_BITS-1:0] now;
    } req_t;

    typedef struct packed {
        logic [2:0]           status;
        logic [HANDLE_W-1:0]  handle_res;
        logic [TIME_BITS-1:0] expires;
        logic [5:0]           count;
        logic                 last;
    } rsp_t;
endpackage

// ===== hdl/tmhq_req_if.sv =====
// Valid/ready channel interface for request items.
interface tmhq_req_if;
    import tmhq_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/tmhq_rsp_if.sv =====
// Valid/ready channel interface for result items.
interface tmhq_rsp_if;
    import tmhq_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== hdl/timer_min_heap_queue_core.sv =====
// Timer queue kept as a binary min-heap in a synchronous memory.
// An add sifts the new entry up from the last slot; pop and delete refill the hole with the last
// entry and sift it down (a delete may climb first); top fires each expired root, then reports the root.
// Levels are at most log2 of the depth (5). One item at a time: input is ready again
// the cycle after the last result of the item is loaded into the output register.
// Reset is asynchronous: state, count, handle valid bits and result valid clear at once.
module timer_min_heap_queue_core
    import tmhq_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tmhq_req_if.sink   req,
    tmhq_rsp_if.source rsp
);
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_RDREM  = 4'd2;
    localparam logic [3:0] S_RDLAST = 4'd3;
    localparam logic [3:0] S_LAST   = 4'd4;
    localparam logic [3:0] S_UP     = 4'd5;
    localparam logic [3:0] S_UPCMP  = 4'd6;
    localparam logic [3:0] S_DN     = 4'd7;
    localparam logic [3:0] S_DNL    = 4'd8;
    localparam logic [3:0] S_DNCMP  = 4'd9;
    localparam logic [3:0] S_PLACE  = 4'd10;
    localparam logic [3:0] S_EMIT   = 4'd11;
    localparam logic [3:0] S_RDROOT = 4'd12;
    localparam logic [3:0] S_TOPCHK = 4'd13;

    // Heap memory and handle map.
    entry_t                  heap_mem [HEAP_DEPTH];
    logic [SLOT_W-1:0]       pos_mem  [HANDLE_COUNT];
    logic [HANDLE_COUNT-1:0] queued_reg;

    logic [3:0]          state_reg;
    logic [CNT_W-1:0]    count_reg;
    req_t                req_reg;
    entry_t              mov_reg;      // entry being sifted
    entry_t              rem_reg;      // removed entry
    entry_t              c1_reg;       // left child
    logic [SLOT_W-1:0]   hole_reg;
    logic                delfirst_reg; // delete may still turn downward
    rsp_t                res_reg;      // result waiting for the output register
    logic                rsp_valid_reg;
    rsp_t                rsp_reg;
    entry_t              rd_data;
    logic [SLOT_W-1:0]   pos_rd;
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_idx;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_idx;
    entry_t              wr_data;
    logic [SLOT_W-1:0]   par_idx;
    logic [SLOT_W+1:0]   l_idx;
    logic [SLOT_W+1:0]   r_idx;
    logic [SLOT_W+1:0]   cnt_ext;
    logic                right_ok;
    logic                dn_right;
    entry_t              dn_child;
    logic                emit_go;
    logic [TIME_BITS:0]  sum_w;

    // Memories with registered read; every heap write also updates the handle map.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            heap_mem[wr_idx] <= wr_data;
            pos_mem[wr_data.handle] <= wr_idx;
        end
        if (rd_en)
            rd_data <= heap_mem[rd_idx];
        pos_rd <= pos_mem[req_reg.handle];
    end

    // Parent and child slots of the hole.
    assign par_idx  = (hole_reg - 1'b1) >> 1;
    assign l_idx    = {1'b0, hole_reg, 1'b1};
    assign r_idx    = l_idx + 1'b1;
    assign cnt_ext  = {1'b0, count_reg};
    assign right_ok = (r_idx < cnt_ext);

    // Down step choice: the right child unless it expires strictly later than the left.
    assign dn_right = right_ok && !(rd_data.expiry > c1_reg.expiry);
    assign dn_child = dn_right ? rd_data : c1_reg;

    assign sum_w = {1'b0, req_reg.now} + {{(TIME_BITS+1-DELAY_W){1'b0}}, req_reg.delay};

    assign emit_go   = (state_reg == S_EMIT) && (!rsp_valid_reg || rsp.ready);
    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_reg;

    // Memory port control per state.
    always_comb
    begin
        rd_en   = 1'b0;
        rd_idx  = '0;
        wr_en   = 1'b0;
        wr_idx  = hole_reg;
        wr_data = mov_reg;
        case (state_reg)
            S_RDREM:
            begin
                rd_en  = 1'b1;
                rd_idx = (req_reg.mode == MODE_DEL) ? pos_rd : hole_reg;
            end
            S_RDLAST:
            begin
                rd_en  = 1'b1;
                rd_idx = count_reg[SLOT_W-1:0];
            end
            S_UP:
            begin
                rd_en  = 1'b1;
                rd_idx = par_idx;
            end
            S_UPCMP:
            begin
                wr_en   = (rd_data.expiry > mov_reg.expiry);
                wr_data = rd_data;
            end
            S_DN:
            begin
                rd_en  = 1'b1;
                rd_idx = l_idx[SLOT_W-1:0];
            end
            S_DNL:
            begin
                rd_en  = 1'b1;
                rd_idx = r_idx[SLOT_W-1:0];
            end
            S_DNCMP:
            begin
                wr_en   = (mov_reg.expiry > dn_child.expiry);
                wr_data = dn_child;
            end
            S_PLACE:  wr_en = 1'b1;
            S_RDROOT: rd_en = 1'b1;
            default:  ;
        endcase
    end

    // Operation sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            queued_reg   <= '0;
            req_reg      <= '0;
            mov_reg      <= '0;
            rem_reg      <= '0;
            c1_reg       <= '0;
            hole_reg     <= '0;
            delfirst_reg <= 1'b0;
            res_reg      <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        req_reg   <= req.data;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    case (req_reg.mode)
                        MODE_ADD:
                        begin
                            if (queued_reg[req_reg.handle])
                            begin
                                res_reg   <= '{ST_BAD, req_reg.handle, '0, 6'(count_reg), 1'b1};
                                state_reg <= S_EMIT;
                            end
                            else if (count_reg >= CNT_W'(HEAP_DEPTH))
                            begin
                                res_reg   <= '{ST_FULL, req_reg.handle, '0, 6'(count_reg), 1'b1};
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                mov_reg      <= '{req_reg.handle, sum_w[TIME_BITS-1:0]};
                                queued_reg[req_reg.handle] <= 1'b1;
                                hole_reg     <= count_reg[SLOT_W-1:0];
                                count_reg    <= count_reg + 1'b1;
                                res_reg      <= '{ST_ADDED, req_reg.handle, sum_w[TIME_BITS-1:0],
                                                  6'(count_reg + 1'b1), 1'b1};
                                delfirst_reg <= 1'b0;
                                state_reg    <= S_UP;
                            end
                        end
                        MODE_DEL:
                        begin
                            if (!queued_reg[req_reg.handle])
                            begin
                                res_reg   <= '{ST_BAD, req_reg.handle, '0, 6'(count_reg), 1'b1};
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                count_reg <= count_reg - 1'b1;
                                state_reg <= S_RDREM;
                            end
                        end
                        MODE_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_reg   <= '{ST_EMPTY, '0, '0, '0, 1'b1};
                                state_reg <= S_EMIT;
                            end
                            else
                            begin
                                count_reg <= count_reg - 1'b1;
                                hole_reg  <= '0;
                                state_reg <= S_RDREM;
                            end
                        end
                        default:
                        begin
                            state_reg <= S_RDROOT;
                        end
                    endcase
                end
                S_RDREM:
                begin
                    // A delete starts from the slot the handle map gave.
                    if (req_reg.mode == MODE_DEL)
                        hole_reg <= pos_rd;
                    state_reg <= S_RDLAST;
                end
                S_RDLAST:
                begin
                    rem_reg   <= rd_data;
                    state_reg <= S_LAST;
                end
                S_LAST:
                begin
                    // The last entry refills the hole left by the removed one.
                    mov_reg <= rd_data;
                    queued_reg[rem_reg.handle] <= 1'b0;
                    case (req_reg.mode)
                        MODE_DEL:
                            res_reg <= '{ST_DELETED, rem_reg.handle, rem_reg.expiry,
                                         6'(count_reg), 1'b1};
                        MODE_POP:
                            res_reg <= '{ST_POPPED, rem_reg.handle, rem_reg.expiry,
                                         6'(count_reg), 1'b1};
                        default:
                            res_reg <= '{ST_FIRED, rem_reg.handle, rem_reg.expiry,
                                         6'(count_reg), 1'b0};
                    endcase
                    if (req_reg.mode == MODE_DEL && hole_reg != '0)
                    begin
                        delfirst_reg <= 1'b1;
                        state_reg    <= S_UP;
                    end
                    else
                        state_reg <= S_DN;
                end
                S_UP:
                begin
                    state_reg <= (hole_reg == '0) ? S_PLACE : S_UPCMP;
                end
                S_UPCMP:
                begin
                    delfirst_reg <= 1'b0;
                    if (rd_data.expiry > mov_reg.expiry)
                    begin
                        hole_reg  <= par_idx;
                        state_reg <= S_UP;
                    end
                    else if (delfirst_reg)
                        state_reg <= S_DN;
                    else
                        state_reg <= S_PLACE;
                end
                S_DN:
                begin
                    state_reg <= (l_idx < cnt_ext) ? S_DNL : S_PLACE;
                end
                S_DNL:
                begin
                    c1_reg    <= rd_data;
                    state_reg <= S_DNCMP;
                end
                S_DNCMP:
                begin
                    if (mov_reg.expiry > dn_child.expiry)
                    begin
                        hole_reg  <= dn_right ? r_idx[SLOT_W-1:0] : l_idx[SLOT_W-1:0];
                        state_reg <= S_DN;
                    end
                    else
                        state_reg <= S_PLACE;
                end
                S_PLACE: state_reg <= S_EMIT;
                S_EMIT:
                begin
                    if (emit_go)
                        state_reg <= res_reg.last ? S_IDLE : S_RDROOT;
                end
                S_RDROOT:
                begin
                    if (count_reg == '0)
                    begin
                        res_reg   <= '{ST_EMPTY, '0, '0, '0, 1'b1};
                        state_reg <= S_EMIT;
                    end
                    else
                        state_reg <= S_TOPCHK;
                end
                S_TOPCHK:
                begin
                    // Fire the root if it expired, else report it.
                    if (rd_data.expiry < req_reg.now)
                    begin
                        count_reg <= count_reg - 1'b1;
                        hole_reg  <= '0;
                        state_reg <= S_RDREM;
                    end
                    else
                    begin
                        res_reg   <= '{ST_TOP, rd_data.handle, rd_data.expiry,
                                       6'(count_reg), 1'b1};
                        state_reg <= S_EMIT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Output register: loads a result when it is free or being taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_reg       <= '0;
        end
        else if (emit_go)
        begin
            rsp_valid_reg <= 1'b1;
            rsp_reg       <= res_reg;
        end
        else if (rsp.ready)
            rsp_valid_reg <= 1'b0;
    end
endmodule

// ===== hdl/tmhq_checker.sv =====
// Port-level checks of the timer heap queue, bound to the core module.
module tmhq_checker
    import tmhq_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input rsp_t out_data
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken while busy");
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.count <= 6'(HEAP_DEPTH))
        else $error("count above depth");
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == ST_EMPTY |-> out_data.count == '0 && out_data.last)
        else $error("empty result malformed");
endmodule

bind timer_min_heap_queue_core tmhq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(req.valid), .in_ready(req.ready),
    .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
);

// ===== dv/tmhq_sb.sv =====
// Scoreboard class with the timer heap predictor and the queue of expected results.
`timescale 1ns / 100ps
package tmhq_sb_pkg;
    import tmhq_pkg::*;

    class tmhq_scoreboard;
        logic [HANDLE_W-1:0]  slot_handle [HEAP_DEPTH];
        logic [TIME_BITS-1:0] slot_expiry [HEAP_DEPTH];
        int                   handle_slot [HANDLE_COUNT];
        bit                   handle_live [HANDLE_COUNT];
        int                   live_count;
        rsp_t                 pending_results [$];
        int                   error_count;

        function new();
            live_count  = 0;
            error_count = 0;
            foreach (handle_live[i])
            begin
                handle_live[i] = 0;
                handle_slot[i] = 0;
            end
        endfunction

        function int entry_count();
            return live_count;
        endfunction

        function bit is_live(int h);
            return handle_live[h];
        endfunction

        function void queue_result(logic [2:0] st, logic [HANDLE_W-1:0] h,
                                   logic [TIME_BITS-1:0] ex, bit fin);
            rsp_t r;
            r.status     = st;
            r.handle_res = h;
            r.expires    = ex;
            r.count      = 6'(live_count);
            r.last       = fin;
            pending_results.push_back(r);
        endfunction

        function void store_slot(int s, logic [HANDLE_W-1:0] h, logic [TIME_BITS-1:0] ex);
            slot_handle[s] = h;
            slot_expiry[s] = ex;
            handle_slot[h] = s;
        endfunction

        // Move an entry toward the root while its parent expires strictly later.
        function void bubble_up(int hole, logic [HANDLE_W-1:0] h, logic [TIME_BITS-1:0] ex);
            int parent;
            while (hole > 0)
            begin
                parent = (hole - 1) / 2;
                if (!(slot_expiry[parent] > ex))
                    break;
                store_slot(hole, slot_handle[parent], slot_expiry[parent]);
                hole = parent;
            end
            store_slot(hole, h, ex);
        endfunction

        // Move an entry toward the leaves past any strictly earlier child.
        function void bubble_down(int hole, logic [HANDLE_W-1:0] h, logic [TIME_BITS-1:0] ex);
            int child;
            child = 2 * (hole + 1);
            while (child <= live_count)
            begin
                if (child == live_count || slot_expiry[child] > slot_expiry[child-1])
                    child--;
                if (!(ex > slot_expiry[child]))
                    break;
                store_slot(hole, slot_handle[child], slot_expiry[child]);
                hole  = child;
                child = 2 * (hole + 1);
            end
            store_slot(hole, h, ex);
        endfunction

        function void take_root(output logic [HANDLE_W-1:0] h, output logic [TIME_BITS-1:0] ex);
            h  = slot_handle[0];
            ex = slot_expiry[0];
            live_count--;
            bubble_down(0, slot_handle[live_count], slot_expiry[live_count]);
            handle_live[h] = 0;
        endfunction

        // Work out the results of one accepted request.
        function void note_request(req_t q);
            logic [HANDLE_W-1:0]  h;
            logic [TIME_BITS-1:0] ex;
            logic [TIME_BITS-1:0] lex;
            logic [HANDLE_W-1:0]  lh;
            int                   pos;
            case (q.mode)
                MODE_ADD:
                begin
                    if (handle_live[q.handle])
                        queue_result(ST_BAD, q.handle, '0, 1);
                    else if (live_count >= HEAP_DEPTH)
                        queue_result(ST_FULL, q.handle, '0, 1);
                    else
                    begin
                        ex = q.now + TIME_BITS'(q.delay);
                        handle_live[q.handle] = 1;
                        live_count++;
                        bubble_up(live_count - 1, q.handle, ex);
                        queue_result(ST_ADDED, q.handle, ex, 1);
                    end
                end
                MODE_DEL:
                begin
                    if (!handle_live[q.handle] || handle_slot[q.handle] >= live_count)
                        queue_result(ST_BAD, q.handle, '0, 1);
                    else
                    begin
                        pos = handle_slot[q.handle];
                        ex  = slot_expiry[pos];
                        live_count--;
                        lh  = slot_handle[live_count];
                        lex = slot_expiry[live_count];
                        if (pos > 0 && slot_expiry[(pos - 1) / 2] > lex)
                            bubble_up(pos, lh, lex);
                        else
                            bubble_down(pos, lh, lex);
                        handle_live[q.handle] = 0;
                        queue_result(ST_DELETED, q.handle, ex, 1);
                    end
                end
                MODE_POP:
                begin
                    if (live_count == 0)
                        queue_result(ST_EMPTY, '0, '0, 1);
                    else
                    begin
                        take_root(h, ex);
                        queue_result(ST_POPPED, h, ex, 1);
                    end
                end
                default:
                begin
                    while (live_count > 0 && slot_expiry[0] < q.now)
                    begin
                        take_root(h, ex);
                        queue_result(ST_FIRED, h, ex, 0);
                    end
                    if (live_count == 0)
                        queue_result(ST_EMPTY, '0, '0, 1);
                    else
                        queue_result(ST_TOP, slot_handle[0], slot_expiry[0], 1);
                end
            endcase
        endfunction

        // Compare one accepted result with the oldest expectation.
        function void check_result(rsp_t got);
            rsp_t exp_r;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %p", $time, got);
                error_count++;
                return;
            end
            exp_r = pending_results.pop_front();
            if (got.status !== exp_r.status || got.handle_res !== exp_r.handle_res ||
                got.expires !== exp_r.expires || got.count !== exp_r.count ||
                got.last !== exp_r.last)
            begin
                $display("%0t: result mismatch, expected %p, actual %p", $time, exp_r, got);
                error_count++;
            end
        endfunction
    endclass
endpackage

// ===== dv/timer_min_heap_queue_core_tb.sv =====
// Testbench top: drives timer heap requests with bursts and checks every result.
`timescale 1ns / 100ps
module timer_min_heap_queue_core_tb;
    import tmhq_pkg::*;
    import tmhq_sb_pkg::*;

    localparam int RANDOM_ITEMS = 325;
    localparam int CYCLE_LIMIT  = 400000;

    logic clk = 1'b0;
    logic rst_n;
    int   cycle_count = 0;
    bit   hold_start;
    bit   long_hold;

    tmhq_req_if req_ch();
    tmhq_rsp_if rsp_ch();

    tmhq_scoreboard timer_model;

    timer_min_heap_queue_core uut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch.sink),
        .rsp   (rsp_ch.source)
    );

    always #2 clk = ~clk;

    // Cycle counter with the timeout.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Long receiver hold-off, counted here once the sender asks for it.
    initial
    begin
        long_hold = 1'b0;
        wait (hold_start);
        @(posedge clk);
        long_hold <= 1'b1;
        repeat (300) @(posedge clk);
        long_hold <= 1'b0;
    end

    // Receiver: random stall pattern, plus one long hold-off when asked.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else if (long_hold)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= (cycle_count % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    // Check every accepted result.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            timer_model.check_result(rsp_ch.data);
    end

    // Offer one request and wait until it is accepted.
    task automatic send_request(logic [1:0] m, logic [HANDLE_W-1:0] h,
                                logic [DELAY_W-1:0] d, logic [TIME_BITS-1:0] t);
        req_t q;
        q.mode   = m;
        q.handle = h;
        q.delay  = d;
        q.now    = t;
        req_ch.valid <= 1'b1;
        req_ch.data  <= q;
        do
            @(posedge clk);
        while (!req_ch.ready);
        timer_model.note_request(q);
    endtask

    task automatic idle_cycles(int n);
        req_ch.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Random request that mostly keeps the heap busy with well-formed work.
    task automatic send_random(ref logic [TIME_BITS-1:0] clock_now);
        int                  pick;
        logic [1:0]          m;
        logic [HANDLE_W-1:0] h;
        logic [DELAY_W-1:0]  d;
        pick = $urandom_range(0, 99);
        h    = HANDLE_W'($urandom);
        d    = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 400);
        if (pick < 45)
        begin
            m = MODE_ADD;
            // Prefer handles not yet queued most of the time.
            if ($urandom_range(0, 4) != 0)
                repeat (4) if (timer_model.is_live(h)) h = HANDLE_W'($urandom);
        end
        else if (pick < 65)
        begin
            m = MODE_DEL;
            if ($urandom_range(0, 3) != 0)
                repeat (8) if (!timer_model.is_live(h)) h = HANDLE_W'($urandom);
        end
        else if (pick < 75)
            m = MODE_POP;
        else
        begin
            m = MODE_TOP;
            clock_now = clock_now + $urandom_range(0, 150);
        end
        if ($urandom_range(0, 40) == 0)
            clock_now = TIME_BITS'({$urandom, $urandom});
        send_request(m, h, d, clock_now);
    endtask

    initial
    begin
        logic [TIME_BITS-1:0] clock_now;
        int                   burst;
        timer_model   = new();
        hold_start    = 0;
        rst_n         = 1'b0;
        req_ch.valid  = 1'b0;
        req_ch.data   = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty cases, extremes, errors, wraparound and expiry.
        send_request(MODE_POP, '1, '1, '1);
        send_request(MODE_TOP, '0, '0, '0);
        send_request(MODE_DEL, 6'd63, '0, '0);
        send_request(MODE_ADD, 6'd0, '1, '1);
        send_request(MODE_ADD, 6'd63, '0, '0);
        send_request(MODE_ADD, 6'd63, 32'd5, '0);
        send_request(MODE_ADD, 6'd21, 32'd100, 48'hAAAA_5555_AAAA);
        send_request(MODE_ADD, 6'd42, 32'd100, 48'h5555_AAAA_5555);
        send_request(MODE_ADD, 6'd7, 32'd100, 48'h5555_AAAA_5555);
        send_request(MODE_DEL, 6'd42, '1, '1);
        send_request(MODE_DEL, 6'd42, '0, '0);
        send_request(MODE_TOP, '0, '0, 48'h5555_AAAA_5555);
        send_request(MODE_TOP, '1, '1, '1);
        send_request(MODE_ADD, 6'd1, 32'hFFFF_FFFF, 48'd10);
        send_request(MODE_POP, '0, '0, '0);
        send_request(MODE_POP, '0, '0, '0);

        // Fill the heap past full, then stall the receiver while requests pile up.
        for (int i = 0; i < HEAP_DEPTH; i++)
            send_request(MODE_ADD, HANDLE_W'(i + 8), $urandom_range(0, 50), 48'd1000);
        hold_start = 1;
        send_request(MODE_ADD, 6'd2, 32'd1, 48'd1000);
        for (int i = 0; i < 4; i++)
            send_request(MODE_DEL, HANDLE_W'(i + 8), '0, '0);
        send_request(MODE_TOP, '0, '0, 48'd1030);
        send_request(MODE_TOP, '0, '0, 48'd5000);

        // Random part in bursts with gaps.
        clock_now = 48'd5000;
        for (int n = 0; n < RANDOM_ITEMS; n += burst)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst; i++)
                send_random(clock_now);
            if ($urandom_range(0, 2) != 0)
                idle_cycles($urandom_range(1, 20));
        end
        req_ch.valid <= 1'b0;

        while (timer_model.pending_results.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (timer_model.error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

// ===== files.f =====
hdl/tmhq_pkg.sv
hdl/tmhq_req_if.sv
hdl/tmhq_rsp_if.sv
hdl/timer_min_heap_queue_core.sv
hdl/tmhq_checker.sv
dv/tmhq_sb.sv
dv/timer_min_heap_queue_core_tb.sv
